>>> rtl/jcs_pkg.sv
// Shared constants for the joystick calibration sequencer.
// No dependencies; used by the top level, its checker and the bench.
package jcs_pkg;

	localparam int unsigned NUM_DIRECTIONS = 4;

	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned HOLD_W   = 16;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned STEP_W   = 3;
	localparam int unsigned DIR_W    = 2;
	localparam int unsigned CFG_IDX_W  = 2;
	localparam int unsigned CFG_DATA_W = 16;

	localparam logic [SAMPLE_W-1:0] DEAD_LOW_RST  = 12'd1500;
	localparam logic [SAMPLE_W-1:0] DEAD_HIGH_RST = 12'd2600;
	localparam logic [HOLD_W-1:0]   HOLD_MS_RST   = 16'd300;

	localparam logic [STEP_W-1:0] STEP_DONE = STEP_W'(NUM_DIRECTIONS);

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEAD_LOW  = 2'd0,
		CFG_DEAD_HIGH = 2'd1,
		CFG_HOLD_MS   = 2'd2
	} cfg_idx_t;

	localparam logic ACTION_SAMPLE  = 1'b0;
	localparam logic ACTION_RESTART = 1'b1;

endpackage

>>> rtl/joystick_calibration_sequencer_top.sv
// Joystick calibration sequencer: input register, sequencing logic, result register.
// Depends on jcs_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one word per item: action,
//   sample_x, sample_y, now_ms. action high restarts from the first direction.
//   Output channel (out_valid / out_stall) returns exactly one word per item:
//   step_now, captured, captured_direction, captured_x, captured_y, done_res.
//   Configuration channel (cfg_valid / cfg_ready) writes dead_low (index 0),
//   dead_high (index 1) and hold_ms (index 2); cfg_ready is always high and
//   writes must only be made while no item is in flight.
//   An accepted word is held in the input register and is then loaded into
//   the result register, where it is presented with out_valid.
//   Throughput is one item per cycle while the result is not stalled, set by
//   the single stage of compares and one 32-bit subtraction against the step
//   and hold-timer registers.
//   Reset (arst_n low) empties both stages, restores the register defaults
//   and returns to the first direction waiting for centre.
//   While out_stall is high the result word holds; an empty input register
//   still takes one more word, and once both registers hold a word in_stall
//   follows out_stall in the same cycle until the result drains.
module joystick_calibration_sequencer_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  logic                              action,
	input  logic [jcs_pkg::SAMPLE_W-1:0]      sample_x,
	input  logic [jcs_pkg::SAMPLE_W-1:0]      sample_y,
	input  logic [jcs_pkg::TIME_W-1:0]        now_ms,
	output logic                              out_valid,
	input  logic                              out_stall,
	output logic [jcs_pkg::STEP_W-1:0]        step_now,
	output logic                              captured,
	output logic [jcs_pkg::DIR_W-1:0]         captured_direction,
	output logic [jcs_pkg::SAMPLE_W-1:0]      captured_x,
	output logic [jcs_pkg::SAMPLE_W-1:0]      captured_y,
	output logic                              done_res,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [jcs_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [jcs_pkg::CFG_DATA_W-1:0]    cfg_data
);

	logic [jcs_pkg::SAMPLE_W-1:0] dead_low_q, dead_high_q;
	logic [jcs_pkg::HOLD_W-1:0]   hold_ms_q;

	logic                         valid_s1;
	logic                         action_s1;
	logic [jcs_pkg::SAMPLE_W-1:0] x_s1, y_s1;
	logic [jcs_pkg::TIME_W-1:0]   now_s1;

	logic [jcs_pkg::STEP_W-1:0]   step_q;
	logic                         centre_wait_q;
	logic                         hold_run_q;
	logic [jcs_pkg::TIME_W-1:0]   hold_start_q;

	logic valid_s2;
	logic advance, take;

	logic [jcs_pkg::STEP_W-1:0]   step_d;
	logic                         centre_wait_d, hold_run_d;
	logic [jcs_pkg::TIME_W-1:0]   hold_start_d;
	logic                         cap_d;
	logic [jcs_pkg::TIME_W-1:0]   elapsed;
	logic                         centred, moved;

	assign cfg_ready = 1'b1;

	// result register drains or is empty: move the input word on
	assign advance  = valid_s1 && !(valid_s2 && out_stall);
	assign take     = !valid_s1 || advance;
	assign in_stall = !take;
	assign out_valid = valid_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dead_low_q  <= jcs_pkg::DEAD_LOW_RST;
			dead_high_q <= jcs_pkg::DEAD_HIGH_RST;
			hold_ms_q   <= jcs_pkg::HOLD_MS_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				jcs_pkg::CFG_DEAD_LOW:  dead_low_q  <= cfg_data[jcs_pkg::SAMPLE_W-1:0];
				jcs_pkg::CFG_DEAD_HIGH: dead_high_q <= cfg_data[jcs_pkg::SAMPLE_W-1:0];
				jcs_pkg::CFG_HOLD_MS:   hold_ms_q   <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take && in_valid) begin
			action_s1 <= action;
			x_s1      <= sample_x;
			y_s1      <= sample_y;
			now_s1    <= now_ms;
		end
	end

	assign centred = (x_s1 > dead_low_q) && (x_s1 < dead_high_q) &&
	                 (y_s1 > dead_low_q) && (y_s1 < dead_high_q);
	assign moved   = (x_s1 < dead_low_q) || (x_s1 > dead_high_q) ||
	                 (y_s1 < dead_low_q) || (y_s1 > dead_high_q);
	assign elapsed = now_s1 - hold_start_q;

	always_comb begin
		step_d        = step_q;
		centre_wait_d = centre_wait_q;
		hold_run_d    = hold_run_q;
		hold_start_d  = hold_start_q;
		cap_d         = 1'b0;
		if (action_s1 == jcs_pkg::ACTION_RESTART) begin
			step_d        = '0;
			centre_wait_d = 1'b1;
			hold_run_d    = 1'b0;
			hold_start_d  = '0;
		end else if (step_q < jcs_pkg::STEP_DONE) begin
			if (centre_wait_q) begin
				if (centred) begin
					centre_wait_d = 1'b0;
				end
			end else if (!moved) begin
				hold_run_d = 1'b0;
			end else if (!hold_run_q) begin
				hold_run_d   = 1'b1;
				hold_start_d = now_s1;
			end else if (elapsed >= {{(jcs_pkg::TIME_W-jcs_pkg::HOLD_W){1'b0}}, hold_ms_q}) begin
				cap_d         = 1'b1;
				step_d        = step_q + jcs_pkg::STEP_W'(1);
				hold_run_d    = 1'b0;
				centre_wait_d = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q        <= '0;
			centre_wait_q <= 1'b1;
			hold_run_q    <= 1'b0;
			hold_start_q  <= '0;
			valid_s2      <= 1'b0;
		end else begin
			if (advance) begin
				step_q        <= step_d;
				centre_wait_q <= centre_wait_d;
				hold_run_q    <= hold_run_d;
				hold_start_q  <= hold_start_d;
				valid_s2      <= 1'b1;
			end else if (!out_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			step_now           <= step_d;
			captured           <= cap_d;
			captured_direction <= cap_d ? step_q[jcs_pkg::DIR_W-1:0] : '0;
			captured_x         <= cap_d ? x_s1 : '0;
			captured_y         <= cap_d ? y_s1 : '0;
			done_res           <= (step_d >= jcs_pkg::STEP_DONE);
		end
	end

endmodule

>>> rtl/jcs_checker.sv
// Port-level checks for the joystick calibration sequencer, bound to the top level.
// Depends on jcs_pkg and joystick_calibration_sequencer_top.
module jcs_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [jcs_pkg::STEP_W-1:0]     step_now,
	input logic                           captured,
	input logic [jcs_pkg::DIR_W-1:0]      captured_direction,
	input logic [jcs_pkg::SAMPLE_W-1:0]   captured_x,
	input logic [jcs_pkg::SAMPLE_W-1:0]   captured_y,
	input logic                           done_res
);

	// a stalled result word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(step_now) && $stable(captured))
		else $error("result word changed under stall");

	a_no_cap_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !captured |-> captured_x == '0 && captured_y == '0 &&
			captured_direction == '0)
		else $error("capture fields not cleared");

	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> done_res == (step_now == jcs_pkg::STEP_DONE))
		else $error("done flag disagrees with step");

	// a capture always advances the step past the captured direction
	a_cap_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && captured |->
			step_now == ({1'b0, captured_direction} + jcs_pkg::STEP_W'(1)))
		else $error("capture direction and step disagree");

endmodule

bind joystick_calibration_sequencer_top jcs_checker u_jcs_checker (
	.clk                (clk),
	.arst_n             (arst_n),
	.out_valid          (out_valid),
	.out_stall          (out_stall),
	.step_now           (step_now),
	.captured           (captured),
	.captured_direction (captured_direction),
	.captured_x         (captured_x),
	.captured_y         (captured_y),
	.done_res           (done_res)
);

>>> dv/calib_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the joystick calibration sequencer bench: tracks the calibration
// progress for every accepted word and checks each returned progress word.
// Depends on jcs_pkg.
package calib_scoreboard_pkg;
	import jcs_pkg::*;

	typedef struct packed {
		logic [STEP_W-1:0]   step;
		logic                cap;
		logic [DIR_W-1:0]    dir;
		logic [SAMPLE_W-1:0] x;
		logic [SAMPLE_W-1:0] y;
		logic                done;
	} progress_word_t;

	class calib_scoreboard;
		bit [SAMPLE_W-1:0] lo = DEAD_LOW_RST;
		bit [SAMPLE_W-1:0] hi = DEAD_HIGH_RST;
		bit [HOLD_W-1:0]   hold = HOLD_MS_RST;

		bit [STEP_W-1:0] step = '0;
		bit              want_centre = 1'b1;
		bit              timing = 1'b0;
		bit [TIME_W-1:0] t_start = '0;

		progress_word_t progress_q[$];
		int unsigned    errors = 0;

		function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			case (idx)
				CFG_DEAD_LOW:  lo = data[SAMPLE_W-1:0];
				CFG_DEAD_HIGH: hi = data[SAMPLE_W-1:0];
				CFG_HOLD_MS:   hold = data[HOLD_W-1:0];
				default: ;
			endcase
		endfunction

		function void predict_progress(bit act, bit [SAMPLE_W-1:0] sx, bit [SAMPLE_W-1:0] sy,
				bit [TIME_W-1:0] now);
			progress_word_t w;
			bit moved;
			bit [TIME_W-1:0] elapsed;
			w = '0;
			elapsed = now - t_start;
			if (act == ACTION_RESTART) begin
				step = '0;
				want_centre = 1'b1;
				timing = 1'b0;
				t_start = '0;
			end else if (step < STEP_DONE) begin
				if (want_centre) begin
					if (sx > lo && sx < hi && sy > lo && sy < hi)
						want_centre = 1'b0;
				end else begin
					// a reading on a band edge is neither centred nor deflected
					moved = sx < lo || sx > hi || sy < lo || sy > hi;
					if (!moved) begin
						timing = 1'b0;
					end else if (!timing) begin
						timing = 1'b1;
						t_start = now;
					end else if (elapsed >= TIME_W'(hold)) begin
						w.cap = 1'b1;
						w.dir = step[DIR_W-1:0];
						w.x = sx;
						w.y = sy;
						step++;
						timing = 1'b0;
						want_centre = 1'b1;
					end
				end
			end
			w.step = step;
			w.done = step >= STEP_DONE;
			progress_q.push_back(w);
		endfunction

		function int unsigned pending();
			return progress_q.size();
		endfunction

		task report(string msg);
			// keep the log short when the block is badly off
			if (errors < 100)
				$display("MISMATCH at %0t: %s", $realtime, msg);
			errors++;
		endtask

		task check_progress(progress_word_t got);
			progress_word_t want;
			if (progress_q.size() == 0) begin
				report("progress word returned with nothing outstanding");
				return;
			end
			want = progress_q.pop_front();
			if (got.step !== want.step)
				report($sformatf("step_now got %0d want %0d", got.step, want.step));
			if (got.cap !== want.cap)
				report($sformatf("captured got %0b want %0b", got.cap, want.cap));
			if (got.dir !== want.dir)
				report($sformatf("captured_direction got %0d want %0d", got.dir, want.dir));
			if (got.x !== want.x)
				report($sformatf("captured_x got %0d want %0d", got.x, want.x));
			if (got.y !== want.y)
				report($sformatf("captured_y got %0d want %0d", got.y, want.y));
			if (got.done !== want.done)
				report($sformatf("done_res got %0b want %0b", got.done, want.done));
		endtask

		task flush_leftover();
			while (progress_q.size() != 0) begin
				void'(progress_q.pop_front());
				report("progress word never returned");
			end
		endtask
	endclass

endpackage

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// Top of the joystick calibration sequencer bench: clock, reset, stimulus, stall
// pattern, result checking and watchdog. Depends on jcs_pkg, calib_scoreboard_pkg
// and joystick_calibration_sequencer_top.
module tb_top;
	import jcs_pkg::*;
	import calib_scoreboard_pkg::*;

	localparam int unsigned IDLE_LIMIT      = 2000;
	localparam int unsigned HOLD_OFF_CYCLES = 300;
	localparam int unsigned FULL_PHASE      = 140;
	localparam int unsigned SHORT_PHASE     = 60;
	localparam int unsigned SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
	// index with no register behind it
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  action = ACTION_SAMPLE;
	logic [SAMPLE_W-1:0]   sample_x = '0;
	logic [SAMPLE_W-1:0]   sample_y = '0;
	logic [TIME_W-1:0]     now_ms = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [STEP_W-1:0]     step_now;
	logic                  captured;
	logic [DIR_W-1:0]      captured_direction;
	logic [SAMPLE_W-1:0]   captured_x;
	logic [SAMPLE_W-1:0]   captured_y;
	logic                  done_res;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	calib_scoreboard sb = new();

	bit              idling = 1'b0;
	bit              hold_off_req = 1'b0;
	bit [TIME_W-1:0] now_t = '0;
	int unsigned     quiet_cycles = 0;

	joystick_calibration_sequencer_top u_dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (!idling || r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic bit [SAMPLE_W-1:0] centred_val();
		if (int'(sb.hi) > int'(sb.lo) + 1)
			return SAMPLE_W'($urandom_range(int'(sb.hi) - 1, int'(sb.lo) + 1));
		return SAMPLE_W'($urandom);
	endfunction

	function automatic bit [SAMPLE_W-1:0] deflected_val();
		bit below, above;
		below = sb.lo != '0;
		above = int'(sb.hi) != SAMPLE_MAX;
		if (below && (!above || $urandom_range(1) == 0))
			return SAMPLE_W'($urandom_range(int'(sb.lo) - 1, 0));
		if (above)
			return SAMPLE_W'($urandom_range(SAMPLE_MAX, int'(sb.hi) + 1));
		return SAMPLE_W'($urandom);
	endfunction

	function automatic bit [SAMPLE_W-1:0] edge_val();
		return ($urandom_range(1) == 0) ? sb.lo : sb.hi;
	endfunction

	// advance the millisecond clock; now and then land on the hold boundary or jump anywhere
	function automatic bit [TIME_W-1:0] next_time();
		int unsigned r;
		r = $urandom_range(99);
		if (sb.timing && r < 20)
			now_t = sb.t_start + TIME_W'(sb.hold) - TIME_W'($urandom_range(1, 0));
		else if (r < 23)
			now_t = $urandom;
		else
			now_t = now_t + TIME_W'($urandom_range(int'(sb.hold) / 2 + 1, 0));
		return now_t;
	endfunction

	task automatic send_word(bit act, bit [SAMPLE_W-1:0] x, bit [SAMPLE_W-1:0] y,
			bit [TIME_W-1:0] t);
		int unsigned gap;
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		action <= act;
		sample_x <= x;
		sample_y <= y;
		now_ms <= t;
		do @(posedge clk); while (in_stall !== 1'b0);
		sb.predict_progress(act, x, y, t);
	endtask

	// hold the sender until every outstanding word is back and the pipe is empty
	task automatic drain();
		in_valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (cfg_ready !== 1'b1);
		sb.set_reg(idx, data);
	endtask

	// upper data bits are junk for the 12-bit registers and must be dropped
	task automatic configure(bit [SAMPLE_W-1:0] lo, bit [SAMPLE_W-1:0] hi,
			bit [HOLD_W-1:0] hold, bit spare);
		write_reg(CFG_DEAD_LOW, {4'($urandom), lo});
		write_reg(CFG_DEAD_HIGH, {4'($urandom), hi});
		write_reg(CFG_HOLD_MS, hold);
		if (spare)
			write_reg(CFG_SPARE, CFG_DATA_W'($urandom));
		cfg_valid <= 1'b0;
	endtask

	// mostly well-formed calibration walks with random content, some noise and restarts
	task automatic run_phase(int unsigned budget);
		int unsigned r;
		bit [SAMPLE_W-1:0] x, y;
		repeat (budget) begin
			r = $urandom_range(99);
			if (r < 8) begin
				send_word($urandom_range(9) == 0, SAMPLE_W'($urandom), SAMPLE_W'($urandom),
					$urandom);
			end else if (r < 10 || (sb.step >= STEP_DONE && r < 40)) begin
				send_word(ACTION_RESTART, SAMPLE_W'($urandom), SAMPLE_W'($urandom), next_time());
			end else if (sb.step >= STEP_DONE) begin
				send_word(ACTION_SAMPLE, SAMPLE_W'($urandom), SAMPLE_W'($urandom), next_time());
			end else if (sb.want_centre) begin
				if (r < 85) begin
					x = centred_val();
					y = centred_val();
				end else if (r < 93) begin
					x = edge_val();
					y = centred_val();
				end else begin
					x = deflected_val();
					y = SAMPLE_W'($urandom);
				end
				if ($urandom_range(1) == 0)
					send_word(ACTION_SAMPLE, x, y, next_time());
				else
					send_word(ACTION_SAMPLE, y, x, next_time());
			end else begin
				if (r < 18) begin
					x = (r < 14) ? edge_val() : centred_val();
					y = centred_val();
				end else begin
					x = deflected_val();
					y = SAMPLE_W'($urandom);
				end
				if ($urandom_range(1) == 0)
					send_word(ACTION_SAMPLE, x, y, next_time());
				else
					send_word(ACTION_SAMPLE, y, x, next_time());
			end
		end
	endtask

	// receiver: random stalls, plus a long hold-off on request
	initial begin
		int unsigned left, r;
		left = 0;
		forever begin
			@(posedge clk);
			if (hold_off_req) begin
				out_stall <= 1'b1;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				hold_off_req = 1'b0;
				left = 0;
			end else if (left > 0) begin
				out_stall <= 1'b1;
				left--;
			end else if (!idling) begin
				out_stall <= 1'b0;
			end else begin
				r = $urandom_range(99);
				if (r < 80) begin
					out_stall <= 1'b0;
				end else begin
					out_stall <= 1'b1;
					left = (r < 97) ? $urandom_range(2, 0) : $urandom_range(40, 10);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0)
			sb.check_progress('{step_now, captured, captured_direction, captured_x,
				captured_y, done_res});
	end

	always @(posedge clk) begin
		if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
				(cfg_valid && cfg_ready === 1'b1))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	initial begin
		bit [TIME_W-1:0] t;
		int unsigned d;
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;
		@(posedge clk);

		// directed walk on the reset settings
		send_word(ACTION_SAMPLE, '0, '0, '0);
		send_word(ACTION_SAMPLE, DEAD_LOW_RST, 12'd2000, 32'd1);
		send_word(ACTION_SAMPLE, 12'd2000, 12'd2000, 32'd2);
		send_word(ACTION_SAMPLE, SAMPLE_W'(SAMPLE_MAX), 12'd2000, 32'd0);
		send_word(ACTION_SAMPLE, DEAD_HIGH_RST, 12'd2000, 32'd400);
		send_word(ACTION_SAMPLE, SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MAX), 32'd400);
		send_word(ACTION_SAMPLE, '0, 12'd2000, 32'd400 + HOLD_MS_RST - 1);
		send_word(ACTION_SAMPLE, '0, 12'd2000, 32'd400 + HOLD_MS_RST);
		send_word(ACTION_SAMPLE, DEAD_HIGH_RST, DEAD_HIGH_RST, 32'd701);
		send_word(ACTION_SAMPLE, DEAD_LOW_RST + 1, DEAD_HIGH_RST - 1, 32'd702);
		// timer across the wrap of the millisecond counter
		send_word(ACTION_SAMPLE, 12'd2000, '0, 32'hFFFF_FF00);
		send_word(ACTION_SAMPLE, 12'd2000, '0, 32'h0000_0030);
		send_word(ACTION_RESTART, SAMPLE_W'(SAMPLE_MAX), SAMPLE_W'(SAMPLE_MAX), '1);
		t = 32'h8000_0000;
		for (d = 0; d < NUM_DIRECTIONS; d++) begin
			send_word(ACTION_SAMPLE, 12'd2000, 12'd2000, t);
			send_word(ACTION_SAMPLE, SAMPLE_W'(d * 1000), SAMPLE_W'(SAMPLE_MAX - d), t + 1);
			send_word(ACTION_SAMPLE, SAMPLE_W'(d * 1000), SAMPLE_W'(SAMPLE_MAX - d),
				t + 1 + HOLD_MS_RST);
			t += 1000;
		end
		// ignored once finished
		send_word(ACTION_SAMPLE, 12'd2000, 12'd2000, t);
		drain();

		idling = 1'b1;
		configure(DEAD_LOW_RST, DEAD_HIGH_RST, HOLD_MS_RST, 1'b0);
		hold_off_req = 1'b1;
		run_phase(FULL_PHASE);
		drain();

		configure(12'd100, 12'd200, 16'd0, 1'b1);
		run_phase(FULL_PHASE);
		drain();

		idling = 1'b0;
		configure(12'd1, SAMPLE_W'(SAMPLE_MAX - 1), '1, 1'b0);
		run_phase(FULL_PHASE);
		drain();
		idling = 1'b1;

		configure('0, SAMPLE_W'(SAMPLE_MAX), 16'd20, 1'b0);
		run_phase(SHORT_PHASE);
		drain();

		configure(12'd2000, 12'd2000, 16'd50, 1'b0);
		run_phase(SHORT_PHASE);
		drain();

		configure(12'd3000, 12'd1000, 16'd10, 1'b0);
		run_phase(SHORT_PHASE);
		drain();

		configure(SAMPLE_W'(SAMPLE_MAX), '0, '1, 1'b0);
		run_phase(SHORT_PHASE);
		drain();

		configure(12'd2047, 12'd2049, 16'd1, 1'b0);
		run_phase(FULL_PHASE);
		drain();

		repeat (5) begin
			d = $urandom_range(2047, 0);
			configure(SAMPLE_W'(d), SAMPLE_W'($urandom_range(SAMPLE_MAX, d + 2)),
				HOLD_W'($urandom_range(1000, 0)), 1'b0);
			run_phase(FULL_PHASE);
			drain();
		end

		configure(DEAD_LOW_RST, DEAD_HIGH_RST, 16'd5, 1'b0);
		hold_off_req = 1'b1;
		run_phase(FULL_PHASE);
		drain();

		repeat (10) @(posedge clk);
		sb.flush_leftover();
		if (sb.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
